### hdl/fsa_pkg.sv
package fsa_pkg;

   // field widths of the request and result
   localparam int OP_W       = 2;
   localparam int SLOT_W     = 10;
   localparam int GEN_W      = 32;
   localparam int FREE_W     = 11;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic init_write;   // write one entry of the initialisation sweep
      logic accept;       // take the request, read the stack top
      logic gen_read;     // read the generation table
      logic commit;       // update state and load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic init_last;    // sweep is at its last entry
      logic out_free;     // result register can take a new result
   } stat_type;

endpackage

### hdl/fsa_ctrl.sv
module fsa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  fsa_pkg::stat_type stat,
   output fsa_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_INIT = 4'b0001,
      S_IDLE = 4'b0010,
      S_GEN  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_write = 1'b1;
            if (stat.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_GEN;
            end
         end
         S_GEN: begin
            cmd.gen_read = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            // hold here while the previous result is still waiting
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule

### hdl/fsa_datapath.sv
module fsa_datapath #(
   parameter int POOL_SIZE = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fsa_pkg::cmd_type                    cmd,
   output fsa_pkg::stat_type                   stat,
   input  logic [fsa_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fsa_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int IDX_W = $clog2(POOL_SIZE);
   localparam int CNT_W = $clog2(POOL_SIZE + 1);

   logic [IDX_W-1:0]                init_addr_ff, init_addr_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [fsa_pkg::OP_W-1:0]        op_ff;
   logic [fsa_pkg::SLOT_W-1:0]      slot_ff;
   logic [IDX_W-1:0]                stack_rd_ff;
   logic [fsa_pkg::GEN_W-1:0]       gen_rd_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fsa_pkg::RSP_DATA_W-1:0]  rsp_data_ff;

   logic [IDX_W-1:0]                stack_mem [POOL_SIZE];
   logic [fsa_pkg::GEN_W-1:0]       gen_mem   [POOL_SIZE];

   logic [IDX_W-1:0]                pop_addr;
   logic [IDX_W-1:0]                slot_addr;
   logic [IDX_W-1:0]                gen_addr;
   logic                            in_range;
   logic                            empty;
   logic                            full;
   logic [fsa_pkg::GEN_W-1:0]       gen_inc;
   logic                            do_pop;
   logic                            do_push;
   logic [fsa_pkg::SLOT_W-1:0]      granted_w;
   logic [fsa_pkg::GEN_W-1:0]       gen_w;
   logic [fsa_pkg::STATUS_W-1:0]    status_w;

   assign pop_addr  = IDX_W'(count_ff - CNT_W'(1));
   assign slot_addr = IDX_W'(slot_ff);
   assign gen_addr  = (op_ff == fsa_pkg::OP_ALLOC) ? stack_rd_ff : slot_addr;
   assign in_range  = {22'd0, slot_ff} < 32'(POOL_SIZE);
   assign empty     = count_ff == '0;
   assign full      = count_ff == CNT_W'(POOL_SIZE);
   assign gen_inc   = gen_rd_ff + 32'd1;

   assign stat.init_last = init_addr_ff == IDX_W'(POOL_SIZE - 1);
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      do_pop    = 1'b0;
      do_push   = 1'b0;
      granted_w = '0;
      gen_w     = '0;
      status_w  = fsa_pkg::ST_OK;
      unique case (op_ff)
         fsa_pkg::OP_ALLOC: begin
            if (empty) begin
               status_w = fsa_pkg::ST_EMPTY;
            end else begin
               do_pop    = 1'b1;
               granted_w = fsa_pkg::SLOT_W'(stack_rd_ff);
               gen_w     = gen_rd_ff;
            end
         end
         fsa_pkg::OP_FREE: begin
            // range check takes precedence over the full check
            priority if (!in_range) begin
               status_w = fsa_pkg::ST_RANGE;
            end else if (full) begin
               status_w = fsa_pkg::ST_FULL;
            end else begin
               do_push = 1'b1;
               gen_w   = gen_inc;
            end
         end
         fsa_pkg::OP_QUERY: begin
            if (!in_range) begin
               status_w = fsa_pkg::ST_RANGE;
            end else begin
               gen_w = gen_rd_ff;
            end
         end
         default: begin
            // unused code: no operation
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end else if (cmd.commit && do_push) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign init_addr_in = cmd.init_write ? init_addr_ff + IDX_W'(1) : init_addr_ff;
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         init_addr_ff <= '0;
         count_ff     <= CNT_W'(POOL_SIZE);
         rsp_valid_ff <= 1'b0;
      end else begin
         init_addr_ff <= init_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_tdata[1:0];
         slot_ff <= req_tdata[11:2];
      end
      if (cmd.commit) begin
         rsp_data_ff <= {1'b0, status_w, fsa_pkg::FREE_W'(count_in), gen_w, granted_w};
      end
   end

   // free stack: loaded top-down so that pops hand out 0, 1, 2 ...
   always_ff @(posedge clock) begin
      if (cmd.init_write) begin
         stack_mem[init_addr_ff] <= IDX_W'(POOL_SIZE - 1) - init_addr_ff;
      end else if (cmd.commit && do_push) begin
         stack_mem[IDX_W'(count_ff)] <= slot_addr;
      end
      if (cmd.accept) begin
         stack_rd_ff <= stack_mem[pop_addr];
      end
   end

   // generation table
   always_ff @(posedge clock) begin
      if (cmd.init_write) begin
         gen_mem[init_addr_ff] <= 32'd1;
      end else if (cmd.commit && do_push) begin
         gen_mem[slot_addr] <= gen_inc;
      end
      if (cmd.gen_read) begin
         gen_rd_ff <= gen_mem[gen_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hdl/free_list_slot_allocator_core.sv
// Slot allocator over a pool of POOL_SIZE slots, with a 32-bit generation
// count per slot. Each request allocates, frees or queries and gives one
// response carrying the granted slot, the generation, the free count after
// the operation and a status. After reset the block loads the free stack
// and the generation table, with req_tready low. From then on the stack
// top is read as a request is accepted, the generation table is read with
// the popped or requested index in the next cycle, and the update and
// result load follow once the output register is free.
// The response sits in an output register, so a new request is taken while
// the previous response still waits; the update stalls only if that
// response has not been taken by then.
module free_list_slot_allocator_core #(
   parameter int POOL_SIZE = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // operation[1:0], slot_index[11:2], zero[15:12]
   input  logic [fsa_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // granted_index[9:0], slot_generation[41:10], free_slots[52:42],
   // status[54:53], zero[55]
   output logic [fsa_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   fsa_pkg::cmd_type  cmd;
   fsa_pkg::stat_type stat;

   fsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fsa_datapath #(
      .POOL_SIZE (POOL_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### tb/sv/tb_free_list_slot_allocator_core.sv
`timescale 1ns / 1ps

module tb_free_list_slot_allocator_core;
   import fsa_pkg::*;

   localparam int POOL_SLOTS = 1024;
   localparam int IDLE_LIMIT = 5000;    // covers the clearing pass after reset
   localparam int LONG_HOLD  = 80;
   localparam int TAIL_WAIT  = 20;
   localparam logic [OP_W-1:0] OP_NOP = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FREE_W-1:0]   free_slots;
      logic [GEN_W-1:0]    generation;
      logic [SLOT_W-1:0]   granted;
   } slot_result_t;

   // predicts each response from the accepted requests and checks it
   class slot_pool_scoreboard;
      logic [SLOT_W-1:0] free_stack [POOL_SLOTS];
      logic [GEN_W-1:0]  gen_table [POOL_SLOTS];
      int unsigned       free_count;
      slot_result_t      expected_q [$];
      int                errors;

      function new();
         for (int i = 0; i < POOL_SLOTS; i++) begin
            free_stack[i] = SLOT_W'(POOL_SLOTS - 1 - i);
            gen_table[i]  = GEN_W'(1);
         end
         free_count = POOL_SLOTS;
         errors     = 0;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] idx);
         slot_result_t r;
         r = '0;
         r.status = ST_OK;
         case (op)
            OP_ALLOC: begin
               if (free_count == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  free_count--;
                  r.granted    = free_stack[free_count];
                  r.generation = gen_table[r.granted];
               end
            end
            OP_FREE: begin
               if (int'(idx) >= POOL_SLOTS) begin
                  r.status = ST_RANGE;
               end else if (free_count >= POOL_SLOTS) begin
                  r.status = ST_FULL;
               end else begin
                  gen_table[idx]         = gen_table[idx] + 1'b1;
                  r.generation           = gen_table[idx];
                  free_stack[free_count] = idx;
                  free_count++;
               end
            end
            OP_QUERY: begin
               if (int'(idx) >= POOL_SLOTS) r.status = ST_RANGE;
               else r.generation = gen_table[idx];
            end
            default: ;
         endcase
         r.free_slots = FREE_W'(free_count);
         expected_q.push_back(r);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         slot_result_t got, exp;
         got = slot_result_t'(data[$bits(slot_result_t)-1:0]);
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response granted=%0d gen=%0d free=%0d status=%0d",
                     $time, got.granted, got.generation, got.free_slots, got.status);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         if (got !== exp) begin
            $display("%0t: response mismatch", $time);
            $display("   expected granted=%0d gen=%0d free=%0d status=%0d",
                     exp.granted, exp.generation, exp.free_slots, exp.status);
            $display("   actual   granted=%0d gen=%0d free=%0d status=%0d",
                     got.granted, got.generation, got.free_slots, got.status);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   slot_pool_scoreboard sb = new();

   bit quiet      = 1'b0;   // no idling on the response side
   int hold_cycles = 0;     // long back-pressure request for the response side
   int idle_cycles = 0;

   free_list_slot_allocator_core #(
      .POOL_SIZE (POOL_SLOTS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // handshake monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tdata[OP_W-1:0], req_tdata[OP_W+SLOT_W-1:OP_W]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // response side: random stalls, plus one long hold on request
   initial begin : rsp_side
      int stall;
      @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] idx,
                               input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-OP_W-SLOT_W){1'b0}}, idx, op};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic random_ops(input int count, input int w_alloc, input int w_free,
                             input int w_query, input bit gaps);
      int pick;
      logic [OP_W-1:0] op;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < w_alloc) op = OP_ALLOC;
         else if (pick < w_alloc + w_free) op = OP_FREE;
         else if (pick < w_alloc + w_free + w_query) op = OP_QUERY;
         else op = OP_NOP;
         send_request(op, SLOT_W'($urandom_range(0, POOL_SLOTS - 1)), gaps);
      end
   endtask

   // sender pause: wait for every outstanding response
   task automatic wait_responses();
      req_tvalid <= 1'b0;
      // one edge first so the last accepted request has been noted
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: full pool, extremes, re-free of a free slot, unused op code
      send_request(OP_FREE,  10'd0,    1'b0);   // stack already full
      send_request(OP_QUERY, 10'd1023, 1'b0);
      send_request(OP_QUERY, 10'd0,    1'b0);
      send_request(OP_NOP,   10'd1023, 1'b0);
      send_request(OP_ALLOC, 10'd1023, 1'b0);   // index ignored, grants 0
      send_request(OP_ALLOC, 10'd0,    1'b0);
      send_request(OP_FREE,  10'd0,    1'b0);
      send_request(OP_FREE,  10'd0,    1'b0);   // already free, still accepted
      send_request(OP_FREE,  10'd1023, 1'b0);   // full again
      send_request(OP_ALLOC, 10'd0,    1'b0);
      send_request(OP_ALLOC, 10'd0,    1'b0);   // same slot pushed twice
      send_request(OP_QUERY, 10'd0,    1'b0);
      send_request(OP_QUERY, 10'd1,    1'b0);
      send_request(OP_FREE,  10'd1023, 1'b0);
      send_request(OP_QUERY, 10'd1023, 1'b0);
      send_request(OP_ALLOC, 10'd1023, 1'b0);
      send_request(OP_NOP,   10'd0,    1'b0);
      wait_responses();

      // mostly allocations, draining a good part of the pool
      random_ops(400, 85, 5, 8, 1'b1);
      wait_responses();

      // mostly frees, back towards a full stack
      random_ops(200, 5, 85, 8, 1'b1);
      wait_responses();

      // long receiver hold while requests keep coming
      hold_cycles = LONG_HOLD;
      random_ops(30, 40, 40, 15, 1'b0);

      random_ops(150, 40, 40, 15, 1'b1);

      quiet = 1'b1;
      random_ops(60, 40, 40, 15, 1'b0);
      wait_responses();

      repeat (TAIL_WAIT) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### files.f
hdl/fsa_pkg.sv
hdl/fsa_ctrl.sv
hdl/fsa_datapath.sv
hdl/free_list_slot_allocator_core.sv
tb/sv/tb_free_list_slot_allocator_core.sv
